// File: hdl/sdts_pkg.sv
// ----------------------------------------------------------------------------
// sdts_pkg
// Shared constants for the sorted date table: table depth, field widths and
// operation codes.
// ----------------------------------------------------------------------------
package sdts_pkg;

  localparam int DEPTH   = 128;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int TAG_W   = 27;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
  localparam int ENTRY_W = KEY_W + TAG_W;
  localparam int POS_W   = 8;

  localparam int FUNC_W  = 2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

endpackage

// File: hdl/sdts_ram.sv
// ----------------------------------------------------------------------------
// sdts_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sdts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/sorted_date_table_search.sv
// ----------------------------------------------------------------------------
// sorted_date_table_search
// Table of dated records kept in ascending date order, with sorted insert,
// binary search and clear.
// ----------------------------------------------------------------------------
// One item in on the s_axis channel gives exactly one item out on m_axis.
// s_axis_tuser carries the operation (clear, insert, search), s_axis_tdata
// the date and the record tag. The result item carries found flag, position,
// tag of the hit, full flag and the entry count after the operation.
// Items are handled one at a time; s_axis_tready is high only while the
// sequencer is idle. An insert shifts the entries with a later date up,
// since the single table RAM moves one entry per cycle; a search is a binary
// search, each probe being one RAM read and one compare.
// The next item is taken once the result has moved to the output register.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the following result waits in the sequencer
// until the output register is free. Reset empties the table (entry count
// zero) and drops any pending result; no clearing pass over the RAM is needed.
// ----------------------------------------------------------------------------
module sorted_date_table_search
  import sdts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // day, month, year, record_tag
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // found, position, tag_out, table_full,
                                     // entry_count, zero fill
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INS_RD   = 6'b000010,
    ST_INS_CMP  = 6'b000100,
    ST_INS_WR   = 6'b001000,
    ST_SRCH_RD  = 6'b010000,
    ST_SRCH_CMP = 6'b100000
  } state_t;

  // result is pending in a state of its own so stalls at the output hold it
  typedef enum logic [1:0] {
    RS_NONE = 2'b01,
    RS_HELD = 2'b10
  } res_state_t;

  state_t             state;
  res_state_t         res_state;
  logic [KEY_W-1:0]   key;
  logic [TAG_W-1:0]   tag;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hp;
  logic [ADDR_W-1:0]  mid;
  logic [CNT_W-1:0]   count;

  logic               res_found;
  logic [CNT_W-1:0]   res_pos;
  logic [TAG_W-1:0]   res_tag;
  logic               res_full;

  logic               found_q;
  logic [POS_W-1:0]   pos_q;
  logic [TAG_W-1:0]   tag_q;
  logic               full_q;
  logic [POS_W-1:0]   cnt_q;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic [KEY_W-1:0]   rd_key;
  logic [CNT_W-1:0]   k_m1;
  logic [CNT_W-1:0]   k_m2;
  logic [CNT_W:0]     mid_sum;
  logic [ADDR_W-1:0]  mid_calc;
  logic               range_open;
  logic               in_acc;
  logic [FUNC_W-1:0]  func;
  logic               out_free;

  assign func       = s_axis_tuser;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign rd_key     = ram_rd_data[ENTRY_W-1:TAG_W];
  assign k_m1       = k - CNT_W'(1);
  assign k_m2       = k - CNT_W'(2);
  // hp is one past the upper bound, so mid = (lo + hp - 1) / 2
  assign mid_sum    = {1'b0, lo} + {1'b0, hp} - (CNT_W + 1)'(1);
  assign mid_calc   = mid_sum[ADDR_W:1];
  assign range_open = lo < hp;
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE) && (res_state == RS_NONE);

  sdts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = k[ADDR_W-1:0];
    ram_wr_data = {key, tag};
    ram_rd_en   = 1'b0;
    ram_rd_addr = k_m1[ADDR_W-1:0];
    case (state)
      ST_INS_RD: begin
        ram_rd_en = 1'b1;
      end
      ST_INS_CMP: begin
        ram_wr_en = 1'b1;
        if (key < rd_key) begin
          // move entry k-1 up and fetch the one below it
          ram_wr_data = ram_rd_data;
          ram_rd_en   = (k_m1 != '0);
          ram_rd_addr = k_m2[ADDR_W-1:0];
        end
      end
      ST_INS_WR: begin
        ram_wr_en = 1'b1;
      end
      ST_SRCH_RD: begin
        ram_rd_en   = range_open;
        ram_rd_addr = mid_calc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_state <= RS_NONE;
      count     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            key       <= s_axis_tdata[KEY_W-1:0];
            tag       <= s_axis_tdata[ENTRY_W-1:KEY_W];
            res_found <= 1'b0;
            res_pos   <= '0;
            res_tag   <= '0;
            res_full  <= 1'b0;
            case (func)
              FUNC_CLEAR: begin
                count     <= '0;
                res_state <= RS_HELD;
              end
              FUNC_INSERT: begin
                k <= count;
                if (count == CNT_W'(DEPTH)) begin
                  res_full  <= 1'b1;
                  res_state <= RS_HELD;
                end else if (count == '0) begin
                  state <= ST_INS_WR;
                end else begin
                  state <= ST_INS_RD;
                end
              end
              FUNC_SEARCH: begin
                lo    <= '0;
                hp    <= count;
                state <= ST_SRCH_RD;
              end
              default: begin
                res_state <= RS_HELD;
              end
            endcase
          end
        end
        ST_INS_RD: begin
          state <= ST_INS_CMP;
        end
        ST_INS_CMP: begin
          if (key < rd_key) begin
            k <= k_m1;
            if (k_m1 == '0) begin
              state <= ST_INS_WR;
            end
          end else begin
            count     <= count + CNT_W'(1);
            res_pos   <= k;
            res_state <= RS_HELD;
            state     <= ST_IDLE;
          end
        end
        ST_INS_WR: begin
          count     <= count + CNT_W'(1);
          res_pos   <= k;
          res_state <= RS_HELD;
          state     <= ST_IDLE;
        end
        ST_SRCH_RD: begin
          if (range_open) begin
            mid   <= mid_calc;
            state <= ST_SRCH_CMP;
          end else begin
            res_pos   <= lo;
            res_state <= RS_HELD;
            state     <= ST_IDLE;
          end
        end
        ST_SRCH_CMP: begin
          if (rd_key == key) begin
            res_found <= 1'b1;
            res_pos   <= CNT_W'(mid);
            res_tag   <= ram_rd_data[TAG_W-1:0];
            res_state <= RS_HELD;
            state     <= ST_IDLE;
          end else begin
            if (key > rd_key) begin
              lo <= CNT_W'(mid) + CNT_W'(1);
            end else begin
              hp <= CNT_W'(mid);
            end
            state <= ST_SRCH_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (res_state == RS_HELD && out_free) begin
        res_state <= RS_NONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_state == RS_HELD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_state == RS_HELD && out_free) begin
      found_q <= res_found;
      pos_q   <= POS_W'(res_pos);
      tag_q   <= res_tag;
      full_q  <= res_full;
      cnt_q   <= POS_W'(count);
    end
  end

  assign m_axis_tdata = {3'b000, cnt_q, full_q, tag_q, pos_q, found_q};

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_write_in_insert: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == ST_INS_CMP || state == ST_INS_WR))
    else $error("table written outside an insert");

  a_insert_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP || state == ST_INS_WR) |-> k < count + CNT_W'(1) &&
      k < CNT_W'(DEPTH))
    else $error("insert index out of range");

  a_probe_in_table: assert property (@(posedge clk) disable iff (rst)
    state == ST_SRCH_CMP |-> CNT_W'(mid) < count)
    else $error("search probe beyond used entries");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (res_state == RS_HELD && out_free) |=> res_state == RS_NONE && m_axis_tvalid)
    else $error("pending result not moved to output register");

endmodule

// File: test/tb_sorted_date_table_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_date_table_search
// Drives clear, insert and search items into the sorted date table and checks
// every result against a behavioral copy of the table kept in the bench or
// the typed result of a directed item. Directed items cover the empty table,
// extreme and out-of-range dates, duplicates and the unused operation code;
// random phases mix inserts, searches and unused codes, some past full.
// ----------------------------------------------------------------------------
module tb_sorted_date_table_search;
  import sdts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [TAG_W-1:0]  TAG_MAX     = 27'h7FF_FFFF;
  localparam int RAND_ITEMS  = 1100;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 40;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [TAG_W-1:0]   tag;
  } date_item_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [TAG_W-1:0]  tag;
    logic              full;
    logic [POS_W-1:0]  count;
  } table_result_t;

  typedef struct packed {
    date_item_t    item;
    logic          typed;
    table_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // day, month, year, record_tag
  logic [1:0]  s_axis_tuser = '0;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // found, position, tag_out, table_full,
                                    // entry_count, zero fill

  // bench copy of the table
  logic [KEY_W-1:0] tbl_key [DEPTH];
  logic [TAG_W-1:0] tbl_tag [DEPTH];
  int               tbl_used = 0;

  table_result_t pending_results [$];
  int  mismatches   = 0;
  int  results_seen = 0;
  bit  burst_in     = 1'b0;
  bit  burst_out    = 1'b0;
  bit  held_once    = 1'b0;

  localparam stim_row_t DIRECTED [25] = '{
    '{'{FUNC_SEARCH, 5'd1, 4'd1, 12'd2000, 27'd0}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd0}},
    '{'{FUNC_UNUSED, 5'd31, 4'd15, 12'd4095, TAG_MAX}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd0}},
    '{'{FUNC_CLEAR, 5'd31, 4'd15, 12'd4095, TAG_MAX}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd0}},
    '{'{FUNC_INSERT, 5'd31, 4'd12, 12'd4095, TAG_MAX}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd1}},
    '{'{FUNC_INSERT, 5'd0, 4'd0, 12'd0, 27'd0}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd2}},
    '{'{FUNC_INSERT, 5'd1, 4'd1, 12'd2000, 27'h555_5555}, 1'b0, '0},
    '{'{FUNC_INSERT, 5'd31, 4'd15, 12'd4095, 27'h2AA_AAAA}, 1'b0, '0},
    '{'{FUNC_INSERT, 5'd1, 4'd1, 12'd2000, 27'd123}, 1'b0, '0},
    '{'{FUNC_INSERT, 5'd1, 4'd1, 12'd2000, 27'd456}, 1'b0, '0},
    '{'{FUNC_INSERT, 5'd15, 4'd6, 12'd2000, 27'd7}, 1'b0, '0},
    '{'{FUNC_SEARCH, 5'd1, 4'd1, 12'd2000, 27'd0}, 1'b0, '0},
    '{'{FUNC_SEARCH, 5'd0, 4'd0, 12'd0, 27'd0}, 1'b0, '0},
    '{'{FUNC_SEARCH, 5'd31, 4'd15, 12'd4095, 27'd0}, 1'b0, '0},
    '{'{FUNC_SEARCH, 5'd2, 4'd1, 12'd2000, 27'd0}, 1'b0, '0},
    '{'{FUNC_SEARCH, 5'd31, 4'd12, 12'd4095, 27'd0}, 1'b0, '0},
    '{'{FUNC_SEARCH, 5'd1, 4'd1, 12'd4095, TAG_MAX}, 1'b0, '0},
    '{'{FUNC_UNUSED, 5'd1, 4'd1, 12'd2000, 27'd5}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd7}},
    '{'{FUNC_CLEAR, 5'd15, 4'd6, 12'd2000, 27'd9}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd0}},
    '{'{FUNC_SEARCH, 5'd1, 4'd1, 12'd2000, 27'd0}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd0}},
    '{'{FUNC_INSERT, 5'd10, 4'd5, 12'd1990, 27'd99}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd1}},
    '{'{FUNC_SEARCH, 5'd10, 4'd5, 12'd1990, 27'd0}, 1'b1, '{1'b1, 8'd0, 27'd99, 1'b0, 8'd1}},
    '{'{FUNC_SEARCH, 5'd11, 4'd5, 12'd1990, 27'd0}, 1'b1, '{1'b0, 8'd1, 27'd0, 1'b0, 8'd1}},
    '{'{FUNC_SEARCH, 5'd9, 4'd5, 12'd1990, 27'd0}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd1}},
    '{'{FUNC_INSERT, 5'd9, 4'd5, 12'd1990, 27'd1}, 1'b1, '{1'b0, 8'd0, 27'd0, 1'b0, 8'd2}},
    '{'{FUNC_INSERT, 5'd10, 4'd5, 12'd1990, 27'd2}, 1'b1, '{1'b0, 8'd2, 27'd0, 1'b0, 8'd3}}
  };

  sorted_date_table_search dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // applies one item to the bench table and returns what the block reports
  function automatic table_result_t table_op_result(date_item_t it);
    table_result_t    r;
    logic [KEY_W-1:0] key;
    int               k;
    int               lo;
    int               hi;
    int               mid;
    bit               hit;
    r   = '0;
    key = {it.year, it.month, it.day};
    case (it.func)
      FUNC_CLEAR: begin
        tbl_used = 0;
      end
      FUNC_INSERT: begin
        if (tbl_used >= DEPTH) begin
          r.full = 1'b1;
        end else begin
          k = tbl_used;
          // equal dates stay ahead of the new record
          while (k > 0 && key < tbl_key[k-1]) begin
            tbl_key[k] = tbl_key[k-1];
            tbl_tag[k] = tbl_tag[k-1];
            k--;
          end
          tbl_key[k] = key;
          tbl_tag[k] = it.tag;
          tbl_used++;
          r.position = POS_W'(k);
        end
      end
      FUNC_SEARCH: begin
        lo  = 0;
        hi  = tbl_used - 1;
        hit = 1'b0;
        mid = 0;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (tbl_key[mid] == key) hit = 1'b1;
          else if (key > tbl_key[mid]) lo = mid + 1;
          else hi = mid - 1;
        end
        if (hit) begin
          r.found    = 1'b1;
          r.position = POS_W'(mid);
          r.tag      = tbl_tag[mid];
        end else begin
          r.position = POS_W'(lo);
        end
      end
      default: ;
    endcase
    r.count = POS_W'(tbl_used);
    return r;
  endfunction

  // random date item; about a third of the dates repeat one already stored
  function automatic date_item_t draw_date_item(logic [FUNC_W-1:0] func);
    date_item_t       it;
    logic [KEY_W-1:0] k;
    int               sel;
    sel     = $urandom_range(0, 9);
    it.func = func;
    it.tag  = TAG_W'($urandom);
    if (sel < 3 && tbl_used > 0) begin
      k        = tbl_key[$urandom_range(0, tbl_used - 1)];
      it.year  = k[KEY_W-1 -: YEAR_W];
      it.month = k[DAY_W +: MONTH_W];
      it.day   = k[DAY_W-1:0];
    end else if (sel == 3) begin
      it.year  = YEAR_W'($urandom);
      it.month = MONTH_W'($urandom);
      it.day   = DAY_W'($urandom);
    end else begin
      it.year  = YEAR_W'($urandom_range(1990, 1993));
      it.month = MONTH_W'($urandom_range(1, 12));
      it.day   = DAY_W'($urandom_range(1, 31));
    end
    return it;
  endfunction

  task automatic send_item(date_item_t it, logic typed, table_result_t typed_res);
    int            gap;
    table_result_t pred;
    gap = burst_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.tag, it.year, it.month, it.day};
    s_axis_tuser  <= it.func;
    do @(posedge clk); while (!s_axis_tready);
    pred = table_op_result(it);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result side
  initial begin
    int            gap;
    table_result_t exp_r;
    table_result_t act_r;
    @(negedge rst);
    forever begin
      if (results_seen == HOLD_AT && !held_once) begin
        // long stall so the block backs up and drops s_axis_tready
        held_once = 1'b1;
        gap = LONG_HOLD;
      end else begin
        gap = burst_out ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      act_r.found    = m_axis_tdata[0];
      act_r.position = m_axis_tdata[8:1];
      act_r.tag      = m_axis_tdata[35:9];
      act_r.full     = m_axis_tdata[36];
      act_r.count    = m_axis_tdata[44:37];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual %0h",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("found", 32'(exp_r.found), 32'(act_r.found));
        check_field("position", 32'(exp_r.position), 32'(act_r.position));
        check_field("tag_out", 32'(exp_r.tag), 32'(act_r.tag));
        check_field("table_full", 32'(exp_r.full), 32'(act_r.full));
        check_field("entry_count", 32'(exp_r.count), 32'(act_r.count));
      end
      results_seen++;
      if (results_seen % 50 == 0) burst_out = ($urandom_range(0, 2) == 0);
    end
  end

  // item side
  initial begin
    int               sent;
    int               steps;
    int               ins_w;
    int               r;
    int               phase;
    logic [FUNC_W-1:0] f;
    sent  = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);

    while (sent < RAND_ITEMS) begin
      burst_in = ($urandom_range(0, 3) == 0);
      send_item(draw_date_item(FUNC_CLEAR), 1'b0, '0);
      sent++;
      // the first phase and some later ones run the table past full
      if (phase == 0 || $urandom_range(0, 4) == 0) begin
        steps = 200;
        ins_w = 72;
      end else begin
        steps = $urandom_range(5, 60);
        ins_w = 50;
      end
      if (steps > RAND_ITEMS - sent) steps = RAND_ITEMS - sent;
      repeat (steps) begin
        r = $urandom_range(0, 99);
        if (r < 4) f = FUNC_UNUSED;
        else if (r < 4 + ins_w) f = FUNC_INSERT;
        else f = FUNC_SEARCH;
        send_item(draw_date_item(f), 1'b0, '0);
        sent++;
      end
      phase++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sorted_date_table_search: PASS");
    end else begin
      $display("tb_sorted_date_table_search: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_sorted_date_table_search: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hdl/sdts_pkg.sv
hdl/sdts_ram.sv
hdl/sorted_date_table_search.sv
test/tb_sorted_date_table_search.sv
